### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the matrix multiply unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mmu_pkg.sv
// ----------------------------------------------------------------------------
// mmu_pkg
// types, constants and helpers of the matrix multiply unit
// ----------------------------------------------------------------------------
`default_nettype none

package mmu_pkg;

  localparam int MAX_DIM     = 8;
  localparam int VALUE_WIDTH = 32;

  localparam int ELEM_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DIM_W   = 4;
  localparam int POS_W   = 3;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int SH_W    = ACC_W - FRAC_W;
  localparam int SAT_W   = (VALUE_WIDTH < SH_W) ? VALUE_WIDTH : SH_W;

  localparam logic [63:0] SAT_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] REG_A_ROWS     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_B_COLS     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } mmu_state_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [POS_W-1:0]        row_index;
    logic [POS_W-1:0]        col_index;
    logic signed [ELEM_W-1:0] element_value;
  } mmu_in_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [ELEM_W-1:0] out_value;
    logic                    saturated;
    logic                    last;
  } mmu_out_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first_k;
    logic             last_k;
    logic             last_entry;
  } mmu_tag_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             advance;
    logic [IDX_W-1:0] k;
    mmu_tag_t         tag;
  } mmu_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_blocked;
  } mmu_status_t;

  function automatic logic [ADDR_W-1:0] elem_addr(int unsigned r, int unsigned c);
    elem_addr = ADDR_W'(r * MAX_DIM + c);
  endfunction

  function automatic logic [IDX_W-1:0] dim_last(logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_DIM) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(v - 4'd1);
    end
    dim_last = res;
  endfunction

endpackage

`default_nettype wire

### sv/mmu_ram.sv
// ----------------------------------------------------------------------------
// mmu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/mmu_ctrl.sv
// ----------------------------------------------------------------------------
// mmu_ctrl
// sequencer: input handshake, dimension registers and product loop counters
// ----------------------------------------------------------------------------
`default_nettype none

module mmu_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire mmu_pkg::mmu_in_t     in_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [3:0]           cfg_data,
  output      mmu_pkg::mmu_cmd_t    cmd,
  input  wire mmu_pkg::mmu_status_t status
);

  import mmu_pkg::*;

  mmu_state_t       state_r, state_nxt;
  logic [DIM_W-1:0] a_rows_r, inner_size_r, b_cols_r;
  logic [IDX_W-1:0] i_r, j_r, k_r;
  logic [IDX_W-1:0] i_nxt, j_nxt, k_nxt;
  logic [IDX_W-1:0] last_i, last_j, last_k;
  logic             in_accept;
  logic             end_k, end_j, end_i;

  assign last_i = dim_last(a_rows_r);
  assign last_k = dim_last(inner_size_r);
  assign last_j = dim_last(b_cols_r);

  assign end_k = (k_r == last_k);
  assign end_j = (j_r == last_j);
  assign end_i = (i_r == last_i);

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r     <= DIM_RESET;
      inner_size_r <= DIM_RESET;
      b_cols_r     <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_A_ROWS:     a_rows_r     <= cfg_data;
        REG_INNER_SIZE: inner_size_r <= cfg_data;
        REG_B_COLS:     b_cols_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_data.command == CMD_COMPUTE) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.advance && end_k && end_j && end_i) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and loop counters
  always_comb begin
    in_stall           = 1'b1;
    cmd                = '0;
    cmd.advance        = !status.out_blocked;
    cmd.k              = k_r;
    cmd.tag.row        = i_r;
    cmd.tag.col        = j_r;
    cmd.tag.first_k    = (k_r == '0);
    cmd.tag.last_k     = end_k;
    cmd.tag.last_entry = end_i && end_j;
    i_nxt              = i_r;
    j_nxt              = j_r;
    k_nxt              = k_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.wr_a = in_accept && in_data.command == CMD_WRITE_A;
        cmd.wr_b = in_accept && in_data.command == CMD_WRITE_B;
      end
      ST_RUN: begin
        cmd.issue = cmd.advance;
        if (cmd.advance) begin
          if (!end_k) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (!end_j) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              i_nxt = end_i ? '0 : i_r + 1'b1;
            end
          end
        end
      end
      ST_FLUSH: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/mmu_datapath.sv
// ----------------------------------------------------------------------------
// mmu_datapath
// element stores, multiply-accumulate pipeline, saturation and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mmu_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mmu_pkg::mmu_in_t     in_data,
  input  wire mmu_pkg::mmu_cmd_t    cmd,
  output      mmu_pkg::mmu_status_t status,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      mmu_pkg::mmu_out_t    out_data
);

  import mmu_pkg::*;

  logic                    wr_ok;
  logic [ADDR_W-1:0]       wr_addr, a_raddr, b_raddr;
  logic [ELEM_W-1:0]       a_rdata, b_rdata;
  logic                    s1_valid_r, s2_valid_r, s3_valid_r;
  mmu_tag_t                s1_tag_r, s2_tag_r, s3_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, prod_ext;
  logic [SH_W-1:0]         q;
  logic [SH_W-SAT_W:0]     q_top;
  logic                    fits;
  logic                    load;
  logic                    out_valid_r;
  mmu_out_t                out_data_r, out_data_nxt;

  assign wr_ok   = (int'(in_data.row_index) < MAX_DIM) && (int'(in_data.col_index) < MAX_DIM);
  assign wr_addr = elem_addr(in_data.row_index, in_data.col_index);
  assign a_raddr = elem_addr(cmd.tag.row, cmd.k);
  assign b_raddr = elem_addr(cmd.k, cmd.tag.col);

  mmu_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (cmd.wr_a && wr_ok),
    .waddr (wr_addr),
    .wdata (in_data.element_value),
    .re    (cmd.issue),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmu_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (cmd.wr_b && wr_ok),
    .waddr (wr_addr),
    .wdata (in_data.element_value),
    .re    (cmd.issue),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = s2_tag_r.first_k ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (cmd.advance) begin
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r && s2_tag_r.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      s1_tag_r <= cmd.tag;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      prod_r   <= PROD_W'($signed(a_rdata)) * PROD_W'($signed(b_rdata));
      if (s2_valid_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // floor shift of the exact sum, then clip to the value width
  assign q     = acc_r[ACC_W-1:FRAC_W];
  assign q_top = q[SH_W-1:SAT_W-1];
  assign fits  = (&q_top) || !(|q_top);

  always_comb begin
    out_data_nxt.out_row = POS_W'(s3_tag_r.row);
    out_data_nxt.out_col = POS_W'(s3_tag_r.col);
    out_data_nxt.last    = s3_tag_r.last_entry;
    out_data_nxt.saturated = !fits;
    if (fits) begin
      out_data_nxt.out_value = q[ELEM_W-1:0];
    end else if (q[SH_W-1]) begin
      out_data_nxt.out_value = ~SAT_MAX[ELEM_W-1:0];
    end else begin
      out_data_nxt.out_value = SAT_MAX[ELEM_W-1:0];
    end
  end

  assign load = cmd.advance && s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign status.busy        = s1_valid_r || s2_valid_r || s3_valid_r;
  assign status.out_blocked = out_valid_r && out_stall;

endmodule

`default_nettype wire

### sv/matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_unit
// product of two stored signed Q16.16 matrices, streamed out in row-major order
// ----------------------------------------------------------------------------
// Write beats load one element of A or B each and are taken back to back.
// A compute beat holds the input for a_rows * b_cols * inner_size issues
// (each dimension clamped to 1 .. MAX_DIM), one multiply-accumulate a cycle
// through the single read port of each store while no result waits under
// stall, and then while the pipeline drains; one result leaves per inner_size
// issues. While a result waits under stall the whole pipeline holds.
// Sums are exact, floored by 16 bits and clipped with the saturated flag set.
`default_nettype none
`include "assert_macros.svh"

module matrix_multiply_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire mmu_pkg::mmu_in_t  in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      mmu_pkg::mmu_out_t out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [3:0]        cfg_data
);

  import mmu_pkg::*;

  mmu_cmd_t    cmd;
  mmu_status_t status;

  mmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  mmu_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // no beat taken while products are in flight
  `ASSERT_IMPLY(a_idle_empty, !in_stall, !status.busy, "input open with pipeline busy")
  // no read issued while the result register is held
  `ASSERT_IMPLY(a_no_issue_blocked, status.out_blocked, !cmd.issue, "issue while blocked")
  // an issued read always enters the pipeline
  `ASSERT_NEXT(a_issue_busy, cmd.issue, status.busy, "issued read lost")

endmodule

`default_nettype wire

### tb/sv/matrix_multiply_unit_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_unit_tb
// self-checking bench for the stored-matrix Q16.16 multiply unit
// ----------------------------------------------------------------------------
// Loads elements of A and B, issues compute beats and checks every product
// entry against a predictor that keeps its own copy of both stores and of the
// dimension registers. A short directed part covers the value extremes,
// saturation both ways, floor rounding, the unused command, the unused
// register index and clamped dimensions. Randomised phases follow, each under
// its own dimension setting, with idle gaps and stalls on both channels, one
// long receiver hold-off and a product with oversized dimensions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module matrix_multiply_unit_tb;
  import mmu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TOTAL_ITEMS  = 110;

  class product_predictor;
    localparam logic signed [71:0] SUM_MAX = (72'sd1 <<< (VALUE_WIDTH - 1)) - 72'sd1;
    localparam logic signed [71:0] SUM_MIN = -(72'sd1 <<< (VALUE_WIDTH - 1));

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] inner_reg;
    logic [DIM_W-1:0] cols_reg;
    mmu_out_t pending_entries [$];
    int errors;
    int entries_checked;
    int saturations;
    int products;

    function new();
      rows_reg = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      errors = 0;
      entries_checked = 0;
      saturations = 0;
      products = 0;
    endfunction

    static function int dim_used(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void note_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_A_ROWS: rows_reg = val;
        REG_INNER_SIZE: inner_reg = val;
        REG_B_COLS: cols_reg = val;
        default: ;
      endcase
    endfunction

    function void note_beat(mmu_in_t beat);
      int nr;
      int nk;
      int nc;
      int addr;
      longint x;
      longint y;
      longint p;
      logic signed [71:0] acc;
      logic signed [71:0] shifted;
      mmu_out_t e;
      nr = dim_used(rows_reg);
      nk = dim_used(inner_reg);
      nc = dim_used(cols_reg);
      addr = int'(beat.row_index) * MAX_DIM + int'(beat.col_index);
      case (beat.command)
        CMD_WRITE_A: a_mem[addr] = beat.element_value;
        CMD_WRITE_B: b_mem[addr] = beat.element_value;
        CMD_COMPUTE: begin
          products++;
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              acc = '0;
              for (int k = 0; k < nk; k++) begin
                x = a_mem[i * MAX_DIM + k];
                y = b_mem[k * MAX_DIM + j];
                p = x * y;
                acc = acc + p;
              end
              // exact sum, floored by the fraction width, then clipped
              shifted = acc >>> FRAC_W;
              e.saturated = 1'b0;
              if (shifted > SUM_MAX) begin
                shifted = SUM_MAX;
                e.saturated = 1'b1;
              end else if (shifted < SUM_MIN) begin
                shifted = SUM_MIN;
                e.saturated = 1'b1;
              end
              e.out_row = POS_W'(i);
              e.out_col = POS_W'(j);
              e.out_value = shifted[ELEM_W-1:0];
              e.last = (i == nr - 1) && (j == nc - 1);
              pending_entries.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_entry(mmu_out_t got);
      mmu_out_t want;
      if (pending_entries.size() == 0) begin
        report($sformatf("entry row %0d col %0d value %h with nothing pending",
                         got.out_row, got.out_col, got.out_value));
        return;
      end
      want = pending_entries.pop_front();
      entries_checked++;
      if (want.saturated) saturations++;
      if (got.out_row !== want.out_row)
        report($sformatf("out_row got %0d want %0d", got.out_row, want.out_row));
      if (got.out_col !== want.out_col)
        report($sformatf("out_col got %0d want %0d", got.out_col, want.out_col));
      if (got.out_value !== want.out_value)
        report($sformatf("out_value got %h want %h at row %0d col %0d",
                         got.out_value, want.out_value, want.out_row, want.out_col));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated got %b want %b at row %0d col %0d",
                         got.saturated, want.saturated, want.out_row, want.out_col));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b at row %0d col %0d",
                         got.last, want.last, want.out_row, want.out_col));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  mmu_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  mmu_out_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  product_predictor board;

  bit a_written [DEPTH];
  bit b_written [DEPTH];
  int gen_nr = MAX_DIM;
  int gen_nk = MAX_DIM;
  int gen_nc = MAX_DIM;
  int rand_items = 0;
  int beats_sent = 0;
  int cfg_writes = 0;
  int cycle_count = 0;
  bit relaxed = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_run = 0;
  bit stall_now = 1'b0;

  matrix_multiply_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d entries pending",
               cycle_count, board.pending_entries.size());
      $display("status: fail");
      $finish;
    end
  end

  // accepted beats on every channel feed the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) board.note_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_beat(in_data);
      if (out_valid && !out_stall) board.check_entry(out_data);
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_gap();
    if (relaxed) return 0;
    if ($urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  // receiver side, including the long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (relaxed) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_now = ($urandom_range(0, 99) < 30);
        stall_run = stall_now ? idle_len() : $urandom_range(1, 20);
      end
      stall_run--;
      out_stall <= stall_now;
    end
  end

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom();
    if (r < 70) return 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
    if (r < 90) begin
      case ($urandom_range(0, 6))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'h00000000;
        3: return 32'h00000001;
        4: return 32'hffffffff;
        5: return 32'h00010000;
        default: return 32'hffff0000;
      endcase
    end
    return 32'h7fff0000 ^ 32'($urandom_range(0, 16'hffff));
  endfunction

  function automatic mmu_in_t random_beat();
    mmu_in_t b;
    b.command = 2'($urandom_range(0, 3));
    b.row_index = POS_W'($urandom_range(0, 7));
    b.col_index = POS_W'($urandom_range(0, 7));
    b.element_value = $urandom();
    return b;
  endfunction

  function automatic logic [3:0] pick_dim();
    if ($urandom_range(0, 99) < 80) return 4'($urandom_range(1, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic send_beat(mmu_in_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data <= random_beat();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= beat;
    beats_sent++;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
    in_data <= random_beat();
  endtask

  task automatic wait_drained();
    end_burst();
    while (board.pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_dims(logic [3:0] rows, logic [3:0] inner, logic [3:0] cols);
    write_reg(REG_A_ROWS, rows);
    write_reg(REG_INNER_SIZE, inner);
    write_reg(REG_B_COLS, cols);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 4'($urandom()));
    gen_nr = product_predictor::dim_used(rows);
    gen_nk = product_predictor::dim_used(inner);
    gen_nc = product_predictor::dim_used(cols);
  endtask

  task automatic send_write(logic [1:0] cmd, int row, int col, logic [31:0] val);
    mmu_in_t b;
    b.command = cmd;
    b.row_index = POS_W'(row);
    b.col_index = POS_W'(col);
    b.element_value = val;
    if (cmd == CMD_WRITE_A) a_written[row * MAX_DIM + col] = 1'b1;
    else b_written[row * MAX_DIM + col] = 1'b1;
    send_beat(b);
  endtask

  // entries that the next product reads must hold a written value
  task automatic fill_needed();
    for (int i = 0; i < gen_nr; i++)
      for (int k = 0; k < gen_nk; k++)
        if (!a_written[i * MAX_DIM + k]) send_write(CMD_WRITE_A, i, k, pick_value());
    for (int k = 0; k < gen_nk; k++)
      for (int j = 0; j < gen_nc; j++)
        if (!b_written[k * MAX_DIM + j]) send_write(CMD_WRITE_B, k, j, pick_value());
  endtask

  task automatic send_compute();
    mmu_in_t b;
    fill_needed();
    b = random_beat();
    b.command = CMD_COMPUTE;
    send_beat(b);
  endtask

  task automatic send_noise();
    mmu_in_t b;
    b = random_beat();
    b.command = CMD_UNUSED;
    send_beat(b);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      if ($urandom_range(0, 1) == 0)
        send_write(CMD_WRITE_A, $urandom_range(0, gen_nr - 1), $urandom_range(0, gen_nk - 1),
                   pick_value());
      else
        send_write(CMD_WRITE_B, $urandom_range(0, gen_nk - 1), $urandom_range(0, gen_nc - 1),
                   pick_value());
    end else if (r < 68) begin
      send_write(($urandom_range(0, 1) == 0) ? CMD_WRITE_A : CMD_WRITE_B,
                 $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
    end else if (r < 90) begin
      send_compute();
    end else begin
      send_noise();
      return;
    end
    rand_items++;
  endtask

  initial begin
    int phase;
    int n;
    board = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // single-entry products: saturation both ways, floor rounding, unused codes
    set_dims(4'd1, 4'd1, 4'd1);
    write_reg(REG_UNUSED, 4'hf);
    send_write(CMD_WRITE_A, 0, 0, 32'h7fffffff);
    send_write(CMD_WRITE_B, 0, 0, 32'h7fffffff);
    send_compute();
    send_write(CMD_WRITE_B, 0, 0, 32'h80000000);
    send_compute();
    send_write(CMD_WRITE_A, 0, 0, 32'h80000000);
    send_compute();
    send_noise();
    send_write(CMD_WRITE_A, 0, 0, 32'h00000001);
    send_write(CMD_WRITE_B, 0, 0, 32'hffffffff);
    send_compute();
    send_write(CMD_WRITE_A, 7, 7, 32'h80000000);
    send_write(CMD_WRITE_B, 7, 7, 32'h7fffffff);
    send_write(CMD_WRITE_A, 7, 0, 32'h00010000);
    wait_drained();

    // zero and oversized register values clamp to one and to the maximum
    set_dims(4'd0, 4'd0, 4'd15);
    send_write(CMD_WRITE_A, 0, 0, 32'h00010000);
    for (int j = 1; j < MAX_DIM; j++) send_write(CMD_WRITE_B, 0, j, pick_value());
    send_compute();
    wait_drained();

    phase = 0;
    while (phase < 6 || beats_sent < TOTAL_ITEMS) begin
      relaxed = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering beats
        relaxed = 1'b0;
        set_dims(4'd8, 4'd1, 4'd8);
        fill_needed();
        hold_req++;
        send_compute();
        repeat (6) random_item();
        send_compute();
      end else if (phase == 4) begin
        set_dims(4'd9, 4'd2, 4'd12);
        send_compute();
      end else begin
        set_dims(pick_dim(), pick_dim(), pick_dim());
        n = $urandom_range(4, 12);
        repeat (n) begin
          random_item();
          if ($urandom_range(0, 19) == 0) wait_drained();
        end
        send_compute();
      end
      wait_drained();
      phase++;
    end

    $display("sent %0d beats (%0d random) in %0d phases, %0d products, %0d register writes",
             beats_sent, rand_items, phase, board.products, cfg_writes);
    $display("checked %0d product entries, %0d saturated, %0d mismatches",
             board.entries_checked, board.saturations, board.errors);
    if (board.errors == 0 && board.pending_entries.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
